// File: design/utls_pkg.sv
// Package with types, constants and calendar helper functions for the UTC to local time shift.
`default_nettype none

package utls_pkg;

	localparam int YearW    = 14;
	localparam int MonthW   = 4;
	localparam int DayW     = 5;
	localparam int HourW    = 5;
	localparam int WeekdayW = 3;
	localparam int LetterW  = 7;
	localparam int OffsetW  = 8;
	localparam int RedW     = 5;

	localparam int HoursPerDay   = 24;
	localparam int MonthsPerYear = 12;
	localparam int DaysPerWeek   = 7;

	// Register indexes of the configuration port.
	typedef enum logic [0:0] {
		REG_ZONE_OFFSET = 1'b0,
		REG_DST         = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cfg_reg_t           idx;
		logic [OffsetW-1:0] wdata;
	} cfg_write_t;

	typedef struct packed {
		logic [YearW-1:0]    utc_year;
		logic [MonthW-1:0]   utc_month;
		logic [DayW-1:0]     utc_day;
		logic [HourW-1:0]    utc_hour;
		logic [WeekdayW-1:0] utc_weekday;
	} utc_item_t;

	typedef struct packed {
		logic [YearW-1:0]    local_year;
		logic [MonthW-1:0]   local_month;
		logic [DayW-1:0]     local_day;
		logic [HourW-1:0]    local_hour;
		logic [WeekdayW-1:0] local_weekday;
		logic [LetterW-1:0]  zone_letter;
	} local_item_t;

	localparam logic [LetterW-1:0] LowerCaseBit = 7'h20;

	// Truncating remainder by 13 of a signed byte, result in -12..12.
	// The quotient of the magnitude uses 79/1024, which is exact for 0..128.
	function automatic logic signed [RedW-1:0] mod13(input logic signed [OffsetW-1:0] v);
		logic [OffsetW-1:0] mag;
		logic [14:0]        prod;
		logic [4:0]         quo;
		logic [OffsetW-1:0] rem;
		mag  = v[OffsetW-1] ? (~v + 8'd1) : v;
		prod = 15'(mag) * 15'd79;
		quo  = prod[14:10];
		rem  = mag - (8'(quo) * 8'd13);
		mod13 = v[OffsetW-1] ? (5'd0 - rem[RedW-1:0]) : rem[RedW-1:0];
	endfunction

	// Military zone letter for a reduced offset of -12..12.
	function automatic logic [LetterW-1:0] zone_letter_of(input logic signed [RedW-1:0] red);
		logic [7:0] l;
		case (red)
			-5'sd12: l = "Y";
			-5'sd11: l = "X";
			-5'sd10: l = "W";
			-5'sd9:  l = "V";
			-5'sd8:  l = "U";
			-5'sd7:  l = "T";
			-5'sd6:  l = "S";
			-5'sd5:  l = "R";
			-5'sd4:  l = "Q";
			-5'sd3:  l = "P";
			-5'sd2:  l = "O";
			-5'sd1:  l = "N";
			5'sd0:   l = "Z";
			5'sd1:   l = "A";
			5'sd2:   l = "B";
			5'sd3:   l = "C";
			5'sd4:   l = "D";
			5'sd5:   l = "E";
			5'sd6:   l = "F";
			5'sd7:   l = "G";
			5'sd8:   l = "H";
			5'sd9:   l = "I";
			5'sd10:  l = "K";
			5'sd11:  l = "L";
			5'sd12:  l = "M";
			default: l = "Z";
		endcase
		zone_letter_of = l[LetterW-1:0];
	endfunction

	// Gregorian leap year. The quotient by 100 uses 5243/2^19, exact below 2^14.
	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [26:0]      prod;
		logic [7:0]       q100;
		logic [YearW-1:0] r100;
		prod = 27'(y) * 27'd5243;
		q100 = prod[26:19];
		r100 = y - (14'(q100) * 14'd100);
		is_leap = (y[1:0] == 2'b00) && ((r100 != '0) || (q100[1:0] == 2'b00));
	endfunction

	// Month length; months outside 1..12 wrap as ((m - 1) mod 12), but only month 2 gets a leap day.
	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
		input logic leap);
		logic [DayW-1:0] d;
		case (m)
			4'd0:    d = 5'd31;
			4'd1:    d = 5'd31;
			4'd2:    d = leap ? 5'd29 : 5'd28;
			4'd3:    d = 5'd31;
			4'd4:    d = 5'd30;
			4'd5:    d = 5'd31;
			4'd6:    d = 5'd30;
			4'd7:    d = 5'd31;
			4'd8:    d = 5'd31;
			4'd9:    d = 5'd30;
			4'd10:   d = 5'd31;
			4'd11:   d = 5'd30;
			4'd12:   d = 5'd31;
			4'd13:   d = 5'd31;
			4'd14:   d = 5'd28;
			4'd15:   d = 5'd31;
			default: d = 5'd31;
		endcase
		month_days = d;
	endfunction

endpackage

`default_nettype wire

// File: design/utls_hs_if.sv
// Valid/ready handshake interface with a typed payload.
`default_nettype none

interface utls_hs_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/utc_to_local_time_shift_unit.sv
// Top level: shifts a UTC calendar hour to local time and gives the zone letter.
//
// Channels: utc_time takes one UTC item per transaction, local_time returns
// exactly one local item per input item, in order. cfg writes the zone offset
// (index REG_ZONE_OFFSET) and the daylight saving flag (index REG_DST); it is
// always ready and should only be written while no item is in flight.
// The zone offset is reduced modulo 13 when it is written, so items only see a
// small signed offset.
// An item passes through the input register and then the result register
// before it is offered on local_time.
// Throughput: one item per cycle unless local_time stalls. The input register
// refills in the same cycle that it hands its item to the result register.
// Stall: while local_time.ready is low, the result register holds and the
// input register may still take one more item; then utc_time.ready drops.
// Reset: both stages are emptied, the offset is 0 and daylight saving is off.
`default_nettype none

module utc_to_local_time_shift_unit
	import utls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	utls_hs_if.sink   utc_time,
	utls_hs_if.source local_time,
	utls_hs_if.sink   cfg
);

	logic signed [RedW-1:0] red_q;
	logic                   dst_q;

	logic      v_s1;
	utc_item_t item_s1;
	logic        v_s2;
	local_item_t item_s2;

	logic adv2;
	logic take_in;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
			dst_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.idx)
				REG_ZONE_OFFSET: red_q <= mod13(cfg.data.wdata);
				REG_DST:         dst_q <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake control of the two stages.
	assign adv2           = !v_s2 || local_time.ready;
	assign utc_time.ready = !v_s1 || adv2;
	assign take_in        = utc_time.valid && utc_time.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (utc_time.ready) begin
			v_s1 <= utc_time.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= utc_time.data;
		end
	end

	// Date arithmetic on the input register.
	logic signed [5:0]    off;
	logic signed [6:0]    hour_sum;
	logic                 shift;
	logic                 borrow;
	logic                 carry;
	logic                 leap_s1;
	logic                 mon_wrap_b;
	logic [MonthW-1:0]    mon_b;
	logic [DayW-1:0]      len_b;
	logic [DayW-1:0]      len_c;
	logic [DayW:0]        day_inc;
	logic [MonthW:0]      mon_inc;
	logic [3:0]           dow_b;
	local_item_t          res;

	always_comb begin
		off      = {red_q[RedW-1], red_q} + 6'(dst_q);
		hour_sum = 7'(item_s1.utc_hour) + {off[5], off};
		shift    = (off != 6'sd0);
		borrow   = shift && hour_sum[6];
		carry    = shift && !hour_sum[6] && (hour_sum >= 7'sd24);
		leap_s1  = is_leap(item_s1.utc_year);

		mon_wrap_b = (item_s1.utc_month <= 4'd1);
		mon_b      = mon_wrap_b ? (item_s1.utc_month + 4'd11) : (item_s1.utc_month - 4'd1);
		len_b      = month_days(mon_b, leap_s1);
		len_c      = month_days(item_s1.utc_month, leap_s1);
		day_inc    = 6'(item_s1.utc_day) + 6'd1;
		mon_inc    = 5'(item_s1.utc_month) + 5'd1;
		dow_b      = 4'(item_s1.utc_weekday) + 4'd5;

		// With no net shift the sum is the raw hour, so it passes through.
		res.local_year    = item_s1.utc_year;
		res.local_month   = item_s1.utc_month;
		res.local_day     = item_s1.utc_day;
		res.local_hour    = 5'(hour_sum);
		res.local_weekday = item_s1.utc_weekday;
		res.zone_letter   = zone_letter_of(red_q) | (dst_q ? LowerCaseBit : '0);

		if (borrow) begin
			res.local_hour = 5'(hour_sum + 7'sd24);
			if (dow_b >= 4'd7) begin
				res.local_weekday = 3'(dow_b - 4'd7 + 4'd1);
			end else begin
				res.local_weekday = 3'(dow_b + 4'd1);
			end
			if (item_s1.utc_day <= 5'd1) begin
				res.local_day   = item_s1.utc_day - 5'd1 + len_b;
				res.local_month = mon_b;
				if (mon_wrap_b) begin
					res.local_year = item_s1.utc_year - 14'd1;
				end
			end else begin
				res.local_day = item_s1.utc_day - 5'd1;
			end
		end else if (carry) begin
			res.local_hour    = 5'(hour_sum - 7'sd24);
			res.local_weekday = (item_s1.utc_weekday == 3'd7) ? 3'd1
				: (item_s1.utc_weekday + 3'd1);
			if (day_inc > 6'(len_c)) begin
				res.local_day = 5'(day_inc - 6'(len_c));
				if (mon_inc > 5'(MonthsPerYear)) begin
					res.local_month = 4'(mon_inc - 5'(MonthsPerYear));
					res.local_year  = item_s1.utc_year + 14'd1;
				end else begin
					res.local_month = mon_inc[MonthW-1:0];
				end
			end else begin
				res.local_day = day_inc[DayW-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			item_s2 <= res;
		end
	end

	assign local_time.valid = v_s2;
	assign local_time.data  = item_s2;

	// An item in the input register moves on whenever the result register frees up.
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> v_s2)
		else $error("item lost between input and result register");

	a_no_double_shift: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(borrow && carry))
		else $error("day borrow and carry at the same time");

	a_hour_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (item_s1.utc_hour <= 5'd23) |-> (res.local_hour <= 5'd23))
		else $error("local hour out of range for a valid UTC hour");

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		local_time.ready |-> utc_time.ready)
		else $error("input stalled while the output is free");

endmodule

`default_nettype wire

// File: dv/utls_shift_checker.sv
`timescale 1ns / 100ps
// Checker for the UTC to local time shift unit: predicts each local item and compares it.
module utls_shift_checker
	import utls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        utc_valid,
	input  logic        utc_ready,
	input  utc_item_t   utc_data,
	input  logic        local_valid,
	input  logic        local_ready,
	input  local_item_t local_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  cfg_write_t  cfg_data,
	output int          mismatches,
	output int          outstanding
);

	// Military letters from offset -12 up to +12.
	localparam logic [7:0] ZoneLetters [25] = '{
		"Y", "X", "W", "V", "U", "T", "S", "R", "Q", "P", "O", "N", "Z",
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M"
	};

	logic [OffsetW-1:0] zone_offset;
	logic               dst_on;
	local_item_t        expected_local [$];

	function automatic bit leap_year(input int yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// Months outside 1..12 wrap around the year; only month 2 gets a leap day.
	function automatic int month_length(input int mon, input int yr);
		int lengths [12];
		int idx;
		lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		idx = (mon - 1) % 12;
		if (idx < 0) begin
			idx += 12;
		end
		if (mon == 2 && leap_year(yr)) begin
			return 29;
		end
		return lengths[idx];
	endfunction

	function automatic local_item_t shift_to_local(input utc_item_t u,
		input logic [OffsetW-1:0] zone, input logic dst);
		int          yr;
		int          mon;
		int          dy;
		int          hr;
		int          wd;
		int          red;
		int          shift;
		int          len;
		local_item_t r;
		yr    = int'(u.utc_year);
		mon   = int'(u.utc_month);
		dy    = int'(u.utc_day);
		hr    = int'(u.utc_hour);
		wd    = int'(u.utc_weekday);
		red   = int'($signed(zone)) % 13;
		shift = red + (dst ? 1 : 0);
		// A zero net shift leaves every date field alone, in range or not.
		if (shift != 0) begin
			hr += shift;
			if (hr < 0) begin
				dy -= 1;
				if (dy <= 0) begin
					mon -= 1;
					if (mon <= 0) begin
						yr = (yr == 0) ? 16383 : yr - 1;
						mon += 12;
					end
					dy += month_length(mon, yr);
				end
				hr += 24;
				wd = ((wd + 5) % 7) + 1;
			end else if (hr >= 24) begin
				dy += 1;
				len = month_length(mon, yr);
				if (dy > len) begin
					mon += 1;
					if (mon > 12) begin
						yr = (yr == 16383) ? 0 : yr + 1;
						mon -= 12;
					end
					dy -= len;
				end
				hr -= 24;
				wd = (wd % 7) + 1;
			end
		end
		r.local_year    = YearW'(yr);
		r.local_month   = MonthW'(mon);
		r.local_day     = DayW'(dy);
		r.local_hour    = HourW'(hr);
		r.local_weekday = WeekdayW'(wd);
		r.zone_letter   = LetterW'(ZoneLetters[red + 12] + (dst ? 8'd32 : 8'd0));
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		local_item_t want;
		if (!arst_n) begin
			zone_offset = '0;
			dst_on      = 1'b0;
			mismatches  = 0;
			expected_local.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.idx)
					REG_ZONE_OFFSET: zone_offset = cfg_data.wdata;
					REG_DST:         dst_on = cfg_data.wdata[0];
					default: ;
				endcase
			end
			// Retire the oldest prediction before adding one from this edge.
			if (local_valid && local_ready) begin
				if (expected_local.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got %p", $time, local_data);
				end else begin
					want = expected_local.pop_front();
					check_field("local_year", want.local_year, local_data.local_year);
					check_field("local_month", want.local_month, local_data.local_month);
					check_field("local_day", want.local_day, local_data.local_day);
					check_field("local_hour", want.local_hour, local_data.local_hour);
					check_field("local_weekday", want.local_weekday,
						local_data.local_weekday);
					check_field("zone_letter", want.zone_letter, local_data.zone_letter);
				end
			end
			if (utc_valid && utc_ready) begin
				expected_local.push_back(shift_to_local(utc_data, zone_offset, dst_on));
			end
			outstanding <= expected_local.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the UTC to local time shift unit: clock, reset, stimulus and verdict.
module tb_top
	import utls_pkg::*;
();

	localparam int CycleLimit    = 200000;
	localparam int Phases        = 12;
	localparam int ItemsPerPhase = 63;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   mismatches;
	int   outstanding;
	bit   quiet_src;
	bit   quiet_snk;

	utls_hs_if #(.payload_t(utc_item_t))   utc_if ();
	utls_hs_if #(.payload_t(local_item_t)) local_if ();
	utls_hs_if #(.payload_t(cfg_write_t))  cfg_if ();

	utc_to_local_time_shift_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.utc_time   (utc_if),
		.local_time (local_if),
		.cfg        (cfg_if)
	);

	utls_shift_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.utc_valid   (utc_if.valid),
		.utc_ready   (utc_if.ready),
		.utc_data    (utc_if.data),
		.local_valid (local_if.valid),
		.local_ready (local_if.ready),
		.local_data  (local_if.data),
		.cfg_valid   (cfg_if.valid),
		.cfg_ready   (cfg_if.ready),
		.cfg_data    (cfg_if.data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int idle_cycles(input bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 14));
	endfunction

	// Result side: a random stall before each result is taken.
	initial begin
		int gap;
		local_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_cycles(quiet_snk);
			if (gap > 0) begin
				local_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			local_if.ready <= 1'b1;
			do @(posedge clk); while (!local_if.valid);
		end
	end

	// Valid stays high between back-to-back transactions; it only drops for a gap.
	task automatic send_utc(input int yr, input int mon, input int dy, input int hr,
		input int wd);
		int gap;
		gap = idle_cycles(quiet_src);
		if (gap > 0) begin
			utc_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		utc_if.valid <= 1'b1;
		utc_if.data  <= '{utc_year: YearW'(yr), utc_month: MonthW'(mon),
			utc_day: DayW'(dy), utc_hour: HourW'(hr), utc_weekday: WeekdayW'(wd)};
		do @(posedge clk); while (!utc_if.ready);
	endtask

	task automatic drain_results();
		utc_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic configure(input logic signed [OffsetW-1:0] zone, input logic dst);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{idx: REG_ZONE_OFFSET, wdata: zone};
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.data  <= '{idx: REG_DST, wdata: {7'd0, dst}};
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		int                        yr;
		int                        mon;
		int                        dy;
		int                        hr;
		int                        wd;
		logic signed [OffsetW-1:0] zone;
		logic                      dst;
		arst_n       = 1'b0;
		utc_if.valid <= 1'b0;
		utc_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		quiet_src    = 1'b0;
		quiet_snk    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings give no shift, so even nonsense fields pass through.
		send_utc(2024, 6, 15, 12, 3);
		send_utc(16383, 15, 0, 31, 0);
		send_utc(0, 0, 31, 24, 7);

		// Largest westward offset: borrows across days, months and years.
		configure(-8'sd12, 1'b0);
		send_utc(0, 1, 1, 0, 1);
		send_utc(2000, 3, 1, 3, 2);
		send_utc(1900, 3, 1, 5, 0);
		send_utc(2023, 0, 1, 11, 7);
		send_utc(2023, 5, 0, 2, 4);
		send_utc(1, 1, 1, 0, 1);
		send_utc(2023, 8, 15, 23, 5);

		// Top of the register range with daylight saving: carries forward.
		configure(8'sd127, 1'b1);
		send_utc(9998, 12, 31, 20, 7);
		send_utc(2024, 2, 28, 23, 3);
		send_utc(2023, 2, 28, 13, 3);
		send_utc(2023, 15, 31, 31, 6);
		send_utc(2023, 14, 28, 20, 0);
		send_utc(16383, 12, 31, 23, 7);
		send_utc(2023, 13, 30, 12, 2);

		configure(-8'sd128, 1'b1);
		send_utc(2023, 3, 1, 0, 1);
		send_utc(2023, 7, 31, 31, 7);

		// Daylight saving cancels the offset, so the fields pass through.
		configure(-8'sd1, 1'b1);
		send_utc(16383, 15, 31, 31, 7);
		send_utc(0, 0, 0, 0, 0);

		configure(8'sd12, 1'b1);
		send_utc(2023, 12, 31, 23, 7);
		send_utc(2023, 4, 30, 11, 4);

		for (int phase = 0; phase < Phases; phase++) begin
			case (phase)
				0:       begin zone = -8'sd128; dst = 1'b0; end
				1:       begin zone = 8'sd127;  dst = 1'b1; end
				2:       begin zone = -8'sd12;  dst = 1'b1; end
				3:       begin zone = 8'sd12;   dst = 1'b0; end
				default: begin
					zone = OffsetW'($urandom_range(0, 255));
					dst  = 1'($urandom_range(0, 1));
				end
			endcase
			configure(zone, dst);
			quiet_src = (phase == 4) || ($urandom_range(0, 3) == 0);
			quiet_snk = (phase == 4) || ($urandom_range(0, 3) == 0);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				if ($urandom_range(0, 9) < 8) begin
					// In-range fields, biased toward month starts and ends and hours near midnight; the day may exceed the month.
					case ($urandom_range(0, 4))
						0:       yr = $urandom_range(1, 24) * 400;
						1:       yr = $urandom_range(1, 99) * 100;
						2:       yr = ($urandom_range(0, 1) != 0) ? 1 : 9998;
						default: yr = $urandom_range(1, 9998);
					endcase
					mon = $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0:       dy = 1;
						1:       dy = $urandom_range(28, 31);
						default: dy = $urandom_range(1, 31);
					endcase
					case ($urandom_range(0, 2))
						0:       hr = $urandom_range(0, 3);
						1:       hr = $urandom_range(20, 23);
						default: hr = $urandom_range(0, 23);
					endcase
					wd = $urandom_range(1, 7);
				end else begin
					yr  = $urandom_range(0, 16383);
					mon = $urandom_range(0, 15);
					dy  = $urandom_range(0, 31);
					hr  = $urandom_range(0, 31);
					wd  = $urandom_range(0, 7);
				end
				send_utc(yr, mon, dy, hr, wd);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: utc_to_local_time_shift_unit.f
design/utls_pkg.sv
design/utls_hs_if.sv
design/utc_to_local_time_shift_unit.sv
dv/utls_shift_checker.sv
dv/tb_top.sv
